// ===== hw/rtl/rwfb_pkg.sv =====
// shared types and constants for the register write frame builder
package rwfb_pkg;

   typedef logic [15:0] crc_type;
   typedef logic [7:0]  byte_type;

   // control from the frame sequencer to the crc unit
   typedef struct packed {
      logic     clear;
      logic     update;
      byte_type data;
   } crc_ctrl_type;

   localparam crc_type  CRC_POLY_REFLECTED = 16'hA001;
   localparam byte_type HDR_BASE           = 8'h80;
   localparam byte_type HDR_WIDE_FLAG      = 8'h08;

endpackage

// ===== hw/rtl/rwfb_crc_unit.sv =====
// crc-16/arc accumulator, one byte folded in per cycle while update is set
module rwfb_crc_unit
   import rwfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   output crc_type      crc
);

   crc_type crc_ff;
   crc_type crc_in;
   crc_type fold;

   // bitwise reflected division over one byte
   always_comb begin
      fold = crc_ff ^ {8'h00, ctrl.data};
      for (int k = 0; k < 8; k++) begin
         if (fold[0]) begin
            fold = (fold >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            fold = fold >> 1;
         end
      end
   end

   // next value select
   always_comb begin
      crc_in = crc_ff;
      if (ctrl.clear) begin
         crc_in = '0;
      end else if (ctrl.update) begin
         crc_in = fold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

// ===== hw/rtl/register_write_frame_builder.sv =====
// top level: request latch, frame sequencer and output register
// A request is taken when the block is idle and leaves as its command frame, one byte per
// rsp beat: header, board id (kinds 0 to 3), one or two address bytes, byte_count data
// bytes most significant first, then the crc-16/arc low byte and high byte. A frame of
// L bytes (5 to 14) keeps the block busy until its last byte is emitted; while rsp does
// not stall, the sequencer walks the frame one byte a cycle and the crc unit folds in
// one byte a cycle. A byte_count of 0, 7, above 8 or above MAX_DATA_BYTES gives a single
// rejected beat with frame_byte 0 and last_byte set. A stall on rsp holds the sequencer.
module register_write_frame_builder
   import rwfb_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_board_id,
   input  logic [15:0] req_reg_address,
   input  logic [63:0] req_write_data,
   input  logic [3:0]  req_byte_count,
   input  logic [2:0]  req_write_kind,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   output logic        rsp_rejected
);

   // sequencer phases
   localparam logic [2:0] PH_HDR  = 3'd0;
   localparam logic [2:0] PH_ID   = 3'd1;
   localparam logic [2:0] PH_AHI  = 3'd2;
   localparam logic [2:0] PH_ALO  = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CLO  = 3'd5;
   localparam logic [2:0] PH_CHI  = 3'd6;
   localparam logic [2:0] PH_REJ  = 3'd7;

   logic        busy_ff, busy_in;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  dcnt_ff, dcnt_in;
   logic        out_valid_ff, out_valid_in;
   byte_type    out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_rej_ff, out_rej_in;

   byte_type    header_ff;
   byte_type    id_ff;
   logic [15:0] addr_ff;
   logic [63:0] data_ff;
   logic [3:0]  count_ff;
   logic        has_id_ff;
   logic        wide_ff;

   logic         req_fire;
   logic         count_ok;
   logic         wide;
   logic         slot_free;
   logic         emit;
   crc_type      crc;
   crc_ctrl_type crc_ctrl;

   assign req_stall = busy_ff;
   assign req_fire  = req_valid && !busy_ff;
   assign wide      = (req_reg_address > 16'd255);

   // count check
   always_comb begin
      count_ok = (req_byte_count inside {[4'd1:4'd6], 4'd8}) &&
                 (req_byte_count <= 4'(MAX_DATA_BYTES));
   end

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign emit      = busy_ff && slot_free;

   // request latch
   always_ff @(posedge clock) begin
      if (req_fire && count_ok) begin
         header_ff <= HDR_BASE | (wide ? HDR_WIDE_FLAG : 8'h00) |
                      {1'b0, req_write_kind, 4'h0} | {4'h0, req_byte_count};
         id_ff     <= req_board_id;
         addr_ff   <= req_reg_address;
         data_ff   <= req_write_data;
         count_ff  <= req_byte_count;
         has_id_ff <= (req_write_kind <= 3'd3);
         wide_ff   <= wide;
      end
   end

   // frame sequencer
   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      dcnt_in      = dcnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_rej_in   = out_rej_ff;
      crc_ctrl     = '{clear: 1'b0, update: 1'b0, data: 8'h00};

      if (req_fire) begin
         busy_in       = 1'b1;
         phase_in      = count_ok ? PH_HDR : PH_REJ;
         crc_ctrl.clear = 1'b1;
      end

      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b0;
         out_rej_in   = 1'b0;
         case (phase_ff)
            PH_HDR: begin
               out_byte_in = header_ff;
               phase_in    = has_id_ff ? PH_ID : (wide_ff ? PH_AHI : PH_ALO);
            end
            PH_ID: begin
               out_byte_in = id_ff;
               phase_in    = wide_ff ? PH_AHI : PH_ALO;
            end
            PH_AHI: begin
               out_byte_in = addr_ff[15:8];
               phase_in    = PH_ALO;
            end
            PH_ALO: begin
               out_byte_in = addr_ff[7:0];
               phase_in    = PH_DATA;
               dcnt_in     = 3'(count_ff - 4'd1);
            end
            PH_DATA: begin
               out_byte_in = data_ff[{dcnt_ff, 3'b000} +: 8];
               if (dcnt_ff == 3'd0) begin
                  phase_in = PH_CLO;
               end else begin
                  dcnt_in = dcnt_ff - 3'd1;
               end
            end
            PH_CLO: begin
               out_byte_in = crc[7:0];
               phase_in    = PH_CHI;
            end
            PH_CHI: begin
               out_byte_in = crc[15:8];
               out_last_in = 1'b1;
               busy_in     = 1'b0;
            end
            PH_REJ: begin
               out_byte_in = 8'h00;
               out_last_in = 1'b1;
               out_rej_in  = 1'b1;
               busy_in     = 1'b0;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
         // header, id, address and data bytes feed the crc
         crc_ctrl.update = (phase_ff <= PH_DATA);
         crc_ctrl.data   = out_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_HDR;
         dcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         dcnt_ff      <= dcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_rej_ff  <= out_rej_in;
   end

   rwfb_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .crc   (crc)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;
   assign rsp_rejected   = out_rej_ff;

`ifndef SYNTHESIS
   a_rej_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rej_ff |-> out_last_ff && (out_byte_ff == 8'h00))
      else $error("rejected beat without last or with nonzero byte");

   a_fire_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("request taken but sequencer not busy");

   a_load_only_busy: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(busy_ff))
      else $error("result beat appeared while idle");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> out_valid_ff && out_last_ff)
      else $error("sequencer finished without a last beat");
`endif

endmodule
